// ===== rtl/core/gelu_pkg.sv =====
// Shared constants, widths and types for the GELU (tanh form) datapath.
package gelu_pkg;

  // Sample format
  localparam int FRAC_BITS = 12;
  localparam int X_W       = 16;

  // Q24 front end: p = |x| scaled to 24 fraction bits
  localparam int Q24_FRAC = 24;
  localparam int P_SHIFT  = Q24_FRAC - FRAC_BITS;
  localparam int MAG_W    = X_W + 1;
  localparam logic [31:0] ABS_CAP = 32'(6) << FRAC_BITS;

  localparam int P_W    = 27;  // p    <= 6.0 in Q24
  localparam int SQ_W   = 30;  // x^2  <= 36  in Q24
  localparam int CUBE_W = 32;  // x^3  <= 216 in Q24
  localparam int V_W    = 29;
  localparam int U_W    = 28;
  localparam int M_W    = 35;  // 2u in Q30
  localparam int M_SHIFT = 7;
  localparam int K_W    = 6;   // ln2 multiples in 2u, at most 36

  localparam logic [31:0] CUBE_COEF = 32'd192049463;   // 0.044715 in Q32
  localparam logic [31:0] SQRT_2_PI = 32'd3426888095;  // sqrt(2/pi) in Q32

  // Q30 tanh section
  localparam int Q30_FRAC = 30;
  localparam int R_W      = 30;
  localparam int Q_W      = 31;
  localparam logic [R_W-1:0] LN2_Q30 = 30'd744261118;
  localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;

  // k estimate: floor(m * LN2_RECIP / 2^RECIP_SHIFT) is k or k-1
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 11;
  localparam logic [RECIP_W-1:0] LN2_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(LN2_Q30));
  localparam int KEST_SHIFT = RECIP_SHIFT - M_SHIFT;

  localparam int EXP_TERMS = 12;

  // tanh quotient divider
  localparam int NUM_W      = 61;
  localparam int DEN_W      = 32;
  localparam int DIV_Q_W    = 31;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = (DIV_Q_W + DIV_BPS - 1) / DIV_BPS;

  // Register stages from accepting edge to result strobe
  localparam int FRONT_STAGES = 9;
  localparam int PIPE_DEPTH   = FRONT_STAGES + 2 * EXP_TERMS + 1 + DIV_STAGES + 2;

  typedef logic signed [X_W-1:0] x_t;

  typedef struct packed {
    x_t             x;
    logic [K_W-1:0] k;
  } exp_side_t;

endpackage

// ===== rtl/core/gelu_tanh_activation_unit.sv =====
// Top level: GELU activation, tanh form, signed fixed point, fully pipelined.
//
// Usage:
//   Input channel: drive in_x_in (signed, FRAC_BITS fraction bits) and raise
//   start; the word is taken at the rising edge where start is high and busy
//   is low. busy is low at all times except the first cycle after reset, so
//   one word can be taken every clock, back to back.
//   Result channel: out_valid is high for exactly one cycle carrying
//   out_y_out = 0.5*x*(1+tanh(sqrt(2/pi)*(x+0.044715*x^3))), rounded to
//   nearest and saturated. The receiver cannot stall; results leave in order.
// Pipeline: PIPE_DEPTH = 52 register stages from the accepting edge to the
//   result strobe. Throughput: one word per clock while busy is low.
// Depth is set by the 12-term exp series (two stages per term: multiply,
//   then exact reciprocal divide) and the 31-bit tanh quotient divider
//   (two quotient bits per stage, 16 stages).
// Reset: synchronous, active low; clears every valid bit, dropping words in
//   flight. No state survives between words, so no setup is needed.
module gelu_tanh_activation_unit
  import gelu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  x_t   in_x_in,
  output logic out_valid,
  output x_t   out_y_out
);

  // ---------------------------------------------------------------------
  // Stage 0: capture
  // ---------------------------------------------------------------------
  logic busy_r;
  logic vld_s0_r;
  x_t   x_s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      vld_s0_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      vld_s0_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    x_s0_r <= in_x_in;
  end

  assign busy = busy_r;

  // ---------------------------------------------------------------------
  // Stage 1: |x|, clamp at 6.0, scale to Q24
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] x_ext;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_cl;
  logic [P_W-1:0]   p_nxt;
  logic             vld_s1_r;
  logic [P_W-1:0]   p_s1_r;
  x_t               x_s1_r;

  assign x_ext  = {x_s0_r[X_W-1], x_s0_r};
  assign mag    = x_ext[MAG_W-1] ? (~x_ext + MAG_W'(1)) : x_ext;
  assign mag_cl = (32'(mag) > ABS_CAP) ? MAG_W'(ABS_CAP) : mag;
  assign p_nxt  = P_W'(mag_cl) << P_SHIFT;

  // ---------------------------------------------------------------------
  // Stages 2-5: x^2, x^3, inner polynomial, scale by sqrt(2/pi)
  // ---------------------------------------------------------------------
  logic [2*P_W-1:0]    pp;
  logic [SQ_W-1:0]     sq_nxt;
  logic                vld_s2_r;
  logic [SQ_W-1:0]     sq_s2_r;
  logic [P_W-1:0]      p_s2_r;
  x_t                  x_s2_r;

  logic [SQ_W+P_W-1:0] sp;
  logic [CUBE_W-1:0]   c_nxt;
  logic                vld_s3_r;
  logic [CUBE_W-1:0]   c_s3_r;
  logic [P_W-1:0]      p_s3_r;
  x_t                  x_s3_r;

  logic [63:0]         cc;
  logic [V_W-1:0]      v_nxt;
  logic                vld_s4_r;
  logic [V_W-1:0]      v_s4_r;
  x_t                  x_s4_r;

  logic [63:0]         vs;
  logic [U_W-1:0]      u_nxt;
  logic                vld_s5_r;
  logic [U_W-1:0]      u_s5_r;
  x_t                  x_s5_r;

  assign pp     = (2*P_W)'(p_s1_r) * (2*P_W)'(p_s1_r);
  assign sq_nxt = pp[Q24_FRAC +: SQ_W];

  assign sp    = (SQ_W+P_W)'(sq_s2_r) * (SQ_W+P_W)'(p_s2_r);
  assign c_nxt = sp[Q24_FRAC +: CUBE_W];

  assign cc    = 64'(c_s3_r) * 64'(CUBE_COEF);
  assign v_nxt = V_W'(p_s3_r) + V_W'(cc[63:32]);

  assign vs    = 64'(v_s4_r) * 64'(SQRT_2_PI);
  assign u_nxt = U_W'(vs[63:32]);

  // ---------------------------------------------------------------------
  // Stages 6-8: m = 2u in Q30, split as k*ln2 + r with 0 <= r < ln2
  // ---------------------------------------------------------------------
  logic [U_W+RECIP_W-1:0] ur;
  logic [K_W-1:0]         kest_nxt;
  logic                   vld_s6_r;
  logic [K_W-1:0]         kest_s6_r;
  logic [U_W-1:0]         u_s6_r;
  x_t                     x_s6_r;

  logic [M_W:0]           m_ext;
  logic [M_W:0]           kl;
  logic [M_W:0]           r0_full;
  logic                   vld_s7_r;
  logic [R_W:0]           r0_s7_r;
  logic [K_W-1:0]         kest_s7_r;
  x_t                     x_s7_r;

  logic                   r_over;
  logic [R_W-1:0]         r_nxt;
  logic [K_W-1:0]         k_nxt;
  logic                   vld_s8_r;
  logic [R_W-1:0]         r_s8_r;
  exp_side_t              side_s8_r;

  assign ur       = (U_W+RECIP_W)'(u_s5_r) * (U_W+RECIP_W)'(LN2_RECIP);
  assign kest_nxt = K_W'(ur >> KEST_SHIFT);

  assign m_ext   = (M_W+1)'(u_s6_r) << M_SHIFT;
  assign kl      = (M_W+1)'(kest_s6_r) * (M_W+1)'(LN2_Q30);
  assign r0_full = m_ext - kl;

  // estimate is low by at most one multiple of ln2
  assign r_over = (r0_s7_r >= (R_W+1)'(LN2_Q30));
  assign r_nxt  = r_over ? R_W'(r0_s7_r - (R_W+1)'(LN2_Q30)) : R_W'(r0_s7_r);
  assign k_nxt  = r_over ? (kest_s7_r + K_W'(1)) : kest_s7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      vld_s3_r <= 1'b0;
      vld_s4_r <= 1'b0;
      vld_s5_r <= 1'b0;
      vld_s6_r <= 1'b0;
      vld_s7_r <= 1'b0;
      vld_s8_r <= 1'b0;
    end else begin
      vld_s1_r <= vld_s0_r;
      vld_s2_r <= vld_s1_r;
      vld_s3_r <= vld_s2_r;
      vld_s4_r <= vld_s3_r;
      vld_s5_r <= vld_s4_r;
      vld_s6_r <= vld_s5_r;
      vld_s7_r <= vld_s6_r;
      vld_s8_r <= vld_s7_r;
    end
  end

  always_ff @(posedge clk) begin
    p_s1_r      <= p_nxt;
    x_s1_r      <= x_s0_r;
    sq_s2_r     <= sq_nxt;
    p_s2_r      <= p_s1_r;
    x_s2_r      <= x_s1_r;
    c_s3_r      <= c_nxt;
    p_s3_r      <= p_s2_r;
    x_s3_r      <= x_s2_r;
    v_s4_r      <= v_nxt;
    x_s4_r      <= x_s3_r;
    u_s5_r      <= u_nxt;
    x_s5_r      <= x_s4_r;
    kest_s6_r   <= kest_nxt;
    u_s6_r      <= u_s5_r;
    x_s6_r      <= x_s5_r;
    r0_s7_r     <= R_W'(0) + r0_full[R_W:0];
    kest_s7_r   <= kest_s6_r;
    x_s7_r      <= x_s6_r;
    r_s8_r      <= r_nxt;
    side_s8_r.k <= k_nxt;
    side_s8_r.x <= x_s7_r;
  end

  // ---------------------------------------------------------------------
  // exp(-r) series, 2*EXP_TERMS stages
  // ---------------------------------------------------------------------
  logic           exp_vld;
  logic [Q_W-1:0] exp_q;
  exp_side_t      exp_side;

  gelu_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_s8_r),
    .in_r     (r_s8_r),
    .in_side  (side_s8_r),
    .out_vld  (exp_vld),
    .out_q    (exp_q),
    .out_side (exp_side)
  );

  // ---------------------------------------------------------------------
  // z = exp(-2u); tanh = (1-z)/(1+z) rounded, numerator and divisor
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]   z_raw;
  logic [Q_W-1:0]   z;
  logic [Q_W-1:0]   one_m_z;
  logic [DEN_W-1:0] one_p_z;
  logic [NUM_W-1:0] num_nxt;
  logic             vld_z_r;
  logic [NUM_W-1:0] num_z_r;
  logic [DEN_W-1:0] den_z_r;
  x_t               x_z_r;

  assign z_raw   = exp_q >> exp_side.k;
  assign z       = (z_raw > Q30_ONE) ? Q30_ONE : z_raw;
  assign one_m_z = Q30_ONE - z;
  assign one_p_z = DEN_W'(Q30_ONE) + DEN_W'(z);
  assign num_nxt = (NUM_W'(one_m_z) << Q30_FRAC) + NUM_W'(one_p_z >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_z_r <= 1'b0;
    end else begin
      vld_z_r <= exp_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_z_r <= num_nxt;
    den_z_r <= one_p_z;
    x_z_r   <= exp_side.x;
  end

  // ---------------------------------------------------------------------
  // tanh quotient, DIV_STAGES stages
  // ---------------------------------------------------------------------
  logic               div_vld;
  logic [DIV_Q_W-1:0] tanh_q;
  x_t                 div_x;

  gelu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_z_r),
    .in_num  (num_z_r),
    .in_den  (den_z_r),
    .in_x    (x_z_r),
    .out_vld (div_vld),
    .out_quo (tanh_q),
    .out_x   (div_x)
  );

  // ---------------------------------------------------------------------
  // y = x * (1 +/- tanh) / 2, round half up, saturate
  // ---------------------------------------------------------------------
  localparam int G_W    = Q_W + 1;
  localparam int PROD_W = X_W + G_W + 1;

  logic [G_W-1:0]           g;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     vld_p_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] y_full;
  x_t                       y_nxt;
  logic                     out_valid_r;
  x_t                       out_y_r;

  // odd symmetry: negative samples use 1 - tanh(|u|)
  assign g = div_x[X_W-1] ? (G_W'(Q30_ONE) - G_W'(tanh_q))
                          : (G_W'(Q30_ONE) + G_W'(tanh_q));
  assign prod_nxt = $signed(PROD_W'(div_x)) * $signed(PROD_W'(g));

  assign rnd    = prod_r + (PROD_W'(1) << Q30_FRAC);
  assign y_full = rnd >>> (Q30_FRAC + 1);

  always_comb begin
    if (y_full > $signed(PROD_W'(32767))) begin
      y_nxt = x_t'(32767);
    end else if (y_full < -$signed(PROD_W'(32768))) begin
      y_nxt = x_t'(-32768);
    end else begin
      y_nxt = x_t'(y_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_p_r     <= div_vld;
      out_valid_r <= vld_p_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    out_y_r <= y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_y_out = out_y_r;

`ifndef SYNTHESIS
  // every taken word shows up as a result strobe after passing all PIPE_DEPTH stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("result strobe missing");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without a taken word");

  // GELU of a nonnegative sample is nonnegative
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_x_in[X_W-1], PIPE_DEPTH)) |-> !out_y_out[X_W-1])
    else $error("negative result for nonnegative sample");

  // large positive samples pass straight through
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_x_in[X_W-1], PIPE_DEPTH)
     && (32'($past(in_x_in, PIPE_DEPTH)) >= ABS_CAP))
    |-> (out_y_out == $past(in_x_in, PIPE_DEPTH)))
    else $error("large sample not passed through");
`endif

endmodule

// ===== rtl/core/gelu_exp.sv =====
// Pipelined Horner evaluation of exp(-r) in Q30, two stages per series term.
module gelu_exp
  import gelu_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [R_W-1:0] in_r,
  input  exp_side_t      in_side,
  output logic           out_vld,
  output logic [Q_W-1:0] out_q,
  output exp_side_t      out_side
);

  logic           vld_a_r  [EXP_TERMS];
  logic [R_W-1:0] pa_r     [EXP_TERMS];
  logic [R_W-1:0] r_a_r    [EXP_TERMS];
  exp_side_t      side_a_r [EXP_TERMS];

  logic           vld_b_r  [EXP_TERMS];
  logic [Q_W-1:0] q_b_r    [EXP_TERMS];
  logic [R_W-1:0] r_b_r    [EXP_TERMS];
  exp_side_t      side_b_r [EXP_TERMS];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    // term divisor n runs 12 down to 1; exact divide by reciprocal
    localparam int unsigned DIVISOR = EXP_TERMS - j;
    localparam int unsigned LSH     = $clog2(DIVISOR);
    localparam logic [31:0] MAGIC   =
      32'(((64'd1 << (R_W + LSH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic               vld_cur;
    logic [R_W-1:0]     r_cur;
    logic [Q_W-1:0]     q_cur;
    exp_side_t          side_cur;
    logic [R_W+Q_W-1:0] rq;
    logic [R_W-1:0]     pa_nxt;
    logic [63:0]        pm;
    logic [R_W-1:0]     d;
    logic [Q_W-1:0]     q_nxt;

    if (j == 0) begin : g_head
      assign vld_cur  = in_vld;
      assign r_cur    = in_r;
      assign q_cur    = Q30_ONE;
      assign side_cur = in_side;
    end else begin : g_body
      assign vld_cur  = vld_b_r[j-1];
      assign r_cur    = r_b_r[j-1];
      assign q_cur    = q_b_r[j-1];
      assign side_cur = side_b_r[j-1];
    end

    // r*q >> 30 stays below 2^30 since r < ln2 and q <= 1
    assign rq     = (R_W+Q_W)'(r_cur) * (R_W+Q_W)'(q_cur);
    assign pa_nxt = rq[Q30_FRAC +: R_W];

    assign pm    = 64'(pa_r[j]) * 64'(MAGIC);
    assign d     = pm[(R_W + LSH) +: R_W];
    assign q_nxt = Q30_ONE - Q_W'(d);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a_r[j] <= 1'b0;
        vld_b_r[j] <= 1'b0;
      end else begin
        vld_a_r[j] <= vld_cur;
        vld_b_r[j] <= vld_a_r[j];
      end
    end

    always_ff @(posedge clk) begin
      pa_r[j]     <= pa_nxt;
      r_a_r[j]    <= r_cur;
      side_a_r[j] <= side_cur;
      q_b_r[j]    <= q_nxt;
      r_b_r[j]    <= r_a_r[j];
      side_b_r[j] <= side_a_r[j];
    end
  end

  assign out_vld  = vld_b_r[EXP_TERMS-1];
  assign out_q    = q_b_r[EXP_TERMS-1];
  assign out_side = side_b_r[EXP_TERMS-1];

`ifndef SYNTHESIS
  // exp(-r) for r < ln2 stays in (0.5, 1]; zero or overflow means a bad divide
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_q != '0) && (out_q <= Q30_ONE))
    else $error("exp term out of range");
`endif

endmodule

// ===== rtl/core/gelu_div.sv =====
// Pipelined restoring divider for the tanh quotient, DIV_BPS bits per stage.
module gelu_div
  import gelu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]   in_den,
  input  x_t                 in_x,
  output logic               out_vld,
  output logic [DIV_Q_W-1:0] out_quo,
  output x_t                 out_x
);

  logic               vld_r [DIV_STAGES];
  logic [DEN_W-1:0]   rem_r [DIV_STAGES];
  logic [DEN_W-1:0]   den_r [DIV_STAGES];
  logic [DIV_Q_W-1:0] lo_r  [DIV_STAGES];
  logic [DIV_Q_W-1:0] quo_r [DIV_STAGES];
  x_t                 x_r   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic               vld_cur;
    logic [DEN_W-1:0]   rem_cur;
    logic [DEN_W-1:0]   den_cur;
    logic [DIV_Q_W-1:0] lo_cur;
    logic [DIV_Q_W-1:0] quo_cur;
    x_t                 x_cur;
    logic [DEN_W-1:0]   rem_nxt;
    logic [DIV_Q_W-1:0] lo_nxt;
    logic [DIV_Q_W-1:0] quo_nxt;

    if (s == 0) begin : g_head
      // top dividend bits are already below the divisor (den >= 2^30)
      assign vld_cur = in_vld;
      assign rem_cur = DEN_W'(in_num[NUM_W-1:DIV_Q_W]);
      assign lo_cur  = in_num[DIV_Q_W-1:0];
      assign quo_cur = '0;
      assign den_cur = in_den;
      assign x_cur   = in_x;
    end else begin : g_body
      assign vld_cur = vld_r[s-1];
      assign rem_cur = rem_r[s-1];
      assign lo_cur  = lo_r[s-1];
      assign quo_cur = quo_r[s-1];
      assign den_cur = den_r[s-1];
      assign x_cur   = x_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_cur;
      lo_nxt  = lo_cur;
      quo_nxt = quo_cur;
      for (int b = 0; b < DIV_BPS; b++) begin
        if (s * DIV_BPS + b < DIV_Q_W) begin
          rem_nxt = {rem_nxt[DEN_W-2:0], lo_nxt[DIV_Q_W-1]};
          lo_nxt  = {lo_nxt[DIV_Q_W-2:0], 1'b0};
          if (rem_nxt >= den_cur) begin
            rem_nxt = rem_nxt - den_cur;
            quo_nxt = {quo_nxt[DIV_Q_W-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[DIV_Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      lo_r[s]  <= lo_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_cur;
      x_r[s]   <= x_cur;
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_quo = quo_r[DIV_STAGES-1];
  assign out_x   = x_r[DIV_STAGES-1];

endmodule
